/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file of this block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `ASSERT_PROP(lbl, clk, rst_n, !(cond))

`endif

/* rtl/core/gda_pkg.sv */
// Shared constants, types and month-length function for the date adder
package gda_pkg;

  // Offset field width and derived working widths
  localparam int OFFSET_BITS = 17;
  localparam int DAY_W       = 5;
  localparam int MONTH_W     = 4;
  localparam int YEAR_W      = 14;
  localparam int IN_FIELDS_W = DAY_W + MONTH_W + YEAR_W + OFFSET_BITS;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = DAY_W + MONTH_W + YEAR_W;
  localparam int OUT_DATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  // Running day count: start day plus signed offset
  localparam int DSUM_W      = ((OFFSET_BITS > DAY_W + 1) ? OFFSET_BITS : DAY_W + 1) + 1;
  // Running signed year, wide enough for any offset in range
  localparam int YRUN_W      = 17;
  // Year remainder modulo 400
  localparam int YMOD_W      = 9;
  localparam int RED_STEPS   = 6;
  localparam int RED_CNT_W   = 3;

  // Calendar constants
  localparam int MONTHS      = 12;
  localparam int LEAP_DAYS   = 29;
  localparam int LEAP_CYCLE  = 400;
  localparam int CENTURY     = 100;
  localparam int YEAR_MIN    = 1;
  localparam int YEAR_MAX    = 9999;
  localparam int DEC_DAYS    = 31;

  localparam logic [DAY_W-1:0] MONTH_LEN [MONTHS] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Calendar lookup request and response
  typedef struct packed {
    logic [MONTH_W-1:0] month;
    logic [1:0]         year_lo;
    logic [YMOD_W-1:0]  year_mod;
  } cal_req_t;

  typedef struct packed {
    logic [DAY_W-1:0] days_cur;
    logic [DAY_W-1:0] days_prev;
  } cal_rsp_t;

  // Days in a month (1..12), February stretched in a leap year
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    len = DAY_W'(DEC_DAYS);
    if (m >= MONTH_W'(1) && m <= MONTH_W'(MONTHS)) begin
      len = MONTH_LEN[m - MONTH_W'(1)];
    end
    if (m == MONTH_W'(2) && leap) begin
      len = DAY_W'(LEAP_DAYS);
    end
    return len;
  endfunction

endpackage

/* rtl/core/gregorian_date_add_days_top.sv */
// Each request steps through the months crossed by its offset (up to about 2200).
// One shared day adder steps one month per cycle; the year is first reduced modulo 400.
// A new request is taken once the last result is in the output register, also while it waits.
// Reset (rst_ni low, asynchronous) idles the sequencer and drops any pending result.
// Top level of the Gregorian date adder
module gregorian_date_add_days_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: start_day, start_month, start_year, day_offset (from bit 0 up), zero padded
  input  logic [gda_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: result_day, result_month, result_year (from bit 0 up), zero padded
  output logic [gda_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // tuser: out_of_range
  output logic [0:0]                       m_axis_tuser
);
  import gda_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MOD  = 5'b00010,
    S_WRAP = 5'b00100,
    S_STEP = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic signed [DSUM_W-1:0] day_q, day_d;
  logic [MONTH_W-1:0]       month_q, month_d;
  logic signed [YRUN_W-1:0] year_q, year_d;
  logic [YEAR_W-1:0]        rem_q, rem_d;
  logic [RED_CNT_W-1:0]     cnt_q, cnt_d;

  logic                     out_valid_q, out_valid_d;
  logic                     out_load;
  logic [DAY_W-1:0]         res_day_q, res_day_d;
  logic [MONTH_W-1:0]       res_month_q, res_month_d;
  logic [YEAR_W-1:0]        res_year_q, res_year_d;
  logic                     res_flag_q, res_flag_d;

  logic [DAY_W-1:0]                in_day;
  logic [MONTH_W-1:0]              in_month;
  logic [YEAR_W-1:0]               in_year;
  logic signed [OFFSET_BITS-1:0]   in_offset;

  cal_req_t cal_req;
  cal_rsp_t cal_rsp;

  logic signed [DSUM_W-1:0] dim_cur, dim_prev, day_sum;
  logic                     carry_fwd, borrow_back;
  logic [YEAR_W-1:0]        red_sub;
  logic [YEAR_W-1:0]        rem_inc, rem_dec;

  // Unpack the request fields
  assign in_day    = s_axis_tdata[DAY_W-1:0];
  assign in_month  = s_axis_tdata[DAY_W+MONTH_W-1:DAY_W];
  assign in_year   = s_axis_tdata[DAY_W+MONTH_W+YEAR_W-1:DAY_W+MONTH_W];
  assign in_offset = $signed(s_axis_tdata[IN_FIELDS_W-1:DAY_W+MONTH_W+YEAR_W]);

  assign s_axis_tready = (state_q == S_IDLE);

  // Month lengths around the current month
  assign cal_req.month    = month_q;
  assign cal_req.year_lo  = year_q[1:0];
  assign cal_req.year_mod = rem_q[YMOD_W-1:0];

  gda_calendar u_calendar (
    .cal_req_i (cal_req),
    .cal_rsp_o (cal_rsp)
  );

  // Shared day adder: subtract this month or add back the previous one
  assign dim_cur     = DSUM_W'($signed({1'b0, cal_rsp.days_cur}));
  assign dim_prev    = DSUM_W'($signed({1'b0, cal_rsp.days_prev}));
  assign carry_fwd   = (day_q > dim_cur);
  assign borrow_back = (day_q < DSUM_W'(1));
  assign day_sum     = day_q + (borrow_back ? dim_prev : -dim_cur);

  // Year remainder modulo 400, reduction step and +/-1 tracking
  assign red_sub = YEAR_W'(LEAP_CYCLE) << cnt_q;
  assign rem_inc = (rem_q == YEAR_W'(LEAP_CYCLE - 1)) ? '0 : rem_q + YEAR_W'(1);
  assign rem_dec = (rem_q == '0) ? YEAR_W'(LEAP_CYCLE - 1) : rem_q - YEAR_W'(1);

  // Sequence one request: reduce year, wrap month, step months, finish
  always_comb begin
    state_d     = state_q;
    day_d       = day_q;
    month_d     = month_q;
    year_d      = year_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    out_load    = 1'b0;
    res_day_d   = res_day_q;
    res_month_d = res_month_q;
    res_year_d  = res_year_q;
    res_flag_d  = res_flag_q;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          day_d   = DSUM_W'($signed({1'b0, in_day})) + DSUM_W'(in_offset);
          month_d = in_month;
          year_d  = YRUN_W'($signed({1'b0, in_year}));
          rem_d   = in_year;
          cnt_d   = RED_CNT_W'(RED_STEPS - 1);
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        if (rem_q >= red_sub) begin
          rem_d = rem_q - red_sub;
        end
        if (cnt_q == '0) begin
          state_d = S_WRAP;
        end else begin
          cnt_d = cnt_q - RED_CNT_W'(1);
        end
      end
      S_WRAP: begin
        if (month_q > MONTH_W'(MONTHS)) begin
          month_d = month_q - MONTH_W'(MONTHS);
          year_d  = year_q + YRUN_W'(1);
          rem_d   = rem_inc;
        end else if (month_q == '0) begin
          month_d = MONTH_W'(MONTHS);
          year_d  = year_q - YRUN_W'(1);
          rem_d   = rem_dec;
        end
        state_d = S_STEP;
      end
      S_STEP: begin
        priority if (carry_fwd) begin
          day_d = day_sum;
          if (month_q == MONTH_W'(MONTHS)) begin
            month_d = MONTH_W'(1);
            year_d  = year_q + YRUN_W'(1);
            rem_d   = rem_inc;
          end else begin
            month_d = month_q + MONTH_W'(1);
          end
        end else if (borrow_back) begin
          day_d = day_sum;
          if (month_q == MONTH_W'(1)) begin
            month_d = MONTH_W'(MONTHS);
            year_d  = year_q - YRUN_W'(1);
            rem_d   = rem_dec;
          end else begin
            month_d = month_q - MONTH_W'(1);
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // Hold until the output register is free, then load the result, saturated if out of range
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          priority if (year_q < YRUN_W'(YEAR_MIN)) begin
            res_day_d   = DAY_W'(1);
            res_month_d = MONTH_W'(1);
            res_year_d  = YEAR_W'(YEAR_MIN);
            res_flag_d  = 1'b1;
          end else if (year_q > YRUN_W'(YEAR_MAX)) begin
            res_day_d   = DAY_W'(DEC_DAYS);
            res_month_d = MONTH_W'(MONTHS);
            res_year_d  = YEAR_W'(YEAR_MAX);
            res_flag_d  = 1'b1;
          end else begin
            res_day_d   = day_q[DAY_W-1:0];
            res_month_d = month_q;
            res_year_d  = year_q[YEAR_W-1:0];
            res_flag_d  = 1'b0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // Working and result registers
  always_ff @(posedge clk_i) begin
    day_q       <= day_d;
    month_q     <= month_d;
    year_q      <= year_d;
    rem_q       <= rem_d;
    res_day_q   <= res_day_d;
    res_month_q <= res_month_d;
    res_year_q  <= res_year_d;
    res_flag_q  <= res_flag_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'({res_year_q, res_month_q, res_day_q});
  assign m_axis_tuser  = res_flag_q;

endmodule

/* rtl/core/gda_calendar.sv */
// Month-length lookup for the current and the preceding month
module gda_calendar (
  input  gda_pkg::cal_req_t cal_req_i,
  output gda_pkg::cal_rsp_t cal_rsp_o
);
  import gda_pkg::*;

  logic               leap;
  logic [MONTH_W-1:0] prev_month;

  // Leap year: divisible by 4, and not a century unless a multiple of 400
  assign leap = (cal_req_i.year_lo == 2'd0) &&
                (cal_req_i.year_mod != YMOD_W'(CENTURY)) &&
                (cal_req_i.year_mod != YMOD_W'(2 * CENTURY)) &&
                (cal_req_i.year_mod != YMOD_W'(3 * CENTURY));

  // Preceding month; only February uses the leap flag, never across a year
  assign prev_month = (cal_req_i.month == MONTH_W'(1)) ? MONTH_W'(MONTHS)
                                                       : cal_req_i.month - MONTH_W'(1);

  assign cal_rsp_o.days_cur  = month_days(cal_req_i.month, leap);
  assign cal_rsp_o.days_prev = month_days(prev_month, leap);

endmodule

/* rtl/core/gda_checker.sv */
// Port-level checker for the date adder, bound to the top level
`include "assert_macros.svh"

module gda_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [gda_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [gda_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [0:0]                     m_axis_tuser
);
  import gda_pkg::*;

  logic [DAY_W-1:0]   r_day;
  logic [MONTH_W-1:0] r_month;
  logic [YEAR_W-1:0]  r_year;
  logic               in_seen;

  assign r_day   = m_axis_tdata[DAY_W-1:0];
  assign r_month = m_axis_tdata[DAY_W+MONTH_W-1:DAY_W];
  assign r_year  = m_axis_tdata[OUT_FIELDS_W-1:DAY_W+MONTH_W];
  assign in_seen = s_axis_tvalid && (s_axis_tdata != '0 || s_axis_tdata == '0);

  // A stalled result holds
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // A saturated result is one of the two clamp dates
  `ASSERT_PROP(a_sat_date, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tuser[0] |->
      (r_day == DAY_W'(1) && r_month == MONTH_W'(1) && r_year == YEAR_W'(YEAR_MIN)) ||
      (r_day == DAY_W'(DEC_DAYS) && r_month == MONTH_W'(MONTHS) &&
       r_year == YEAR_W'(YEAR_MAX)))

  // Every result has a nonzero day, a month of 1..12 and a year of 1..9999
  `ASSERT_NEVER(a_norm_date, clk_i, rst_ni,
    m_axis_tvalid && (r_day == '0 || r_month == '0 || r_month > MONTH_W'(MONTHS) ||
                      r_year == '0 || r_year > YEAR_W'(YEAR_MAX)))

  // A new result only appears while a request is in work or no request is offered
  `ASSERT_PROP(a_rise_busy, clk_i, rst_ni,
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready || !in_seen))

endmodule

bind gregorian_date_add_days_top gda_checker u_gda_checker (.*);
